>>> hdl/gcpa_pkg.sv
package gcpa_pkg;

  localparam int MAX_NODES    = 32;
  localparam int MAX_CHANNELS = 8;

  localparam int NODE_AW = $clog2(MAX_NODES);
  localparam int NODE_W  = 6;
  localparam int CH_W    = 4;
  localparam int CH_AW   = $clog2(MAX_CHANNELS);
  localparam int LOAD_W  = 16 + $clog2(MAX_NODES) + 1;
  localparam int TOTAL_W = 40;

  localparam int DVD_W  = 66;
  localparam int DVS_W  = 32;
  localparam int DIV_CW = $clog2(DVD_W + 1);
  localparam int RAD_W  = 64;
  localparam int ROOT_W = RAD_W / 2;
  localparam int SQ_CW  = $clog2(ROOT_W + 1);

  localparam logic [63:0] GAIN_K2  = 64'd3320413933267719290;
  localparam logic [31:0] SAT32    = 32'hFFFF_FFFF;
  localparam logic [16:0] Q16_ONE  = 17'h1_0000;

  typedef enum logic [1:0] {
    REG_NODE_COUNT    = 2'd0,
    REG_CHANNEL_COUNT = 2'd1,
    REG_NOISE_POWER   = 2'd2,
    REG_POWER_CAP     = 2'd3
  } cfg_reg_t;

endpackage

>>> hdl/gcpa_div.sv
module gcpa_div
  import gcpa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quot
);

  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W-1:0]  rem;
  logic [DIV_CW-1:0] cnt;
  logic              busy;
  logic [DVS_W:0]    rem_sh;
  logic              ge;

  assign rem_sh = {rem, dvd[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};
  assign quot   = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CW'(DVD_W);
        dvd  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= ge ? DVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[DVS_W-1:0];
        dvd <= {dvd[DVD_W-2:0], ge};
        cnt <= cnt - DIV_CW'(1);
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/gcpa_sqrt.sv
module gcpa_sqrt
  import gcpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0]    rad;
  logic [ROOT_W+1:0]   rem;
  logic [SQ_CW-1:0]    cnt;
  logic                busy;
  logic [ROOT_W+3:0]   rem_sh;
  logic [ROOT_W+3:0]   trial;
  logic                ge;

  assign rem_sh = {rem, rad[RAD_W-1:RAD_W-2]};
  assign trial  = {2'b00, root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= SQ_CW'(ROOT_W);
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rem  <= ge ? (ROOT_W+2)'(rem_sh - trial) : rem_sh[ROOT_W+1:0];
        root <= {root[ROOT_W-2:0], ge};
        rad  <= {rad[RAD_W-3:0], 2'b00};
        cnt  <= cnt - SQ_CW'(1);
        if (cnt == SQ_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/greedy_channel_power_assignment.sv
// load transactions: one per cycle while no run is in progress, no result
// run transaction: gains per node (a bit-serial sqrt, up to four divides), then ranking,
//   then per ranked node and channel a trial (two divides per feasible node), the
//   divides all on the shared bit-serial divider; results then follow in node order
// no transaction is taken from a run until its last result is delivered
// synchronous reset: registers to 20, 4, 1.0 and 10000.0, node memories not cleared
module greedy_channel_power_assignment
  import gcpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              kind,
  input  logic [NODE_W-1:0] node_index,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic [15:0]       target_ratio,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NODE_W-1:0] node_number,
  output logic [CH_W-1:0]   assigned_channel,
  output logic              is_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_value
);

  typedef enum logic [18:0] {
    ST_IDLE   = 19'h00001,
    ST_G_RD   = 19'h00002,
    ST_G_MUL  = 19'h00004,
    ST_G_SQ   = 19'h00008,
    ST_G_DIV  = 19'h00010,
    ST_G_WR   = 19'h00020,
    ST_R_RD   = 19'h00040,
    ST_R_CMP  = 19'h00080,
    ST_A_RD   = 19'h00100,
    ST_A_NODE = 19'h00200,
    ST_L_CLR  = 19'h00400,
    ST_L_RD   = 19'h00800,
    ST_L_ADD  = 19'h01000,
    ST_P_RD   = 19'h02000,
    ST_P_CALC = 19'h04000,
    ST_P_DIV  = 19'h08000,
    ST_A_CMP  = 19'h10000,
    ST_O_RD   = 19'h20000,
    ST_O_SHOW = 19'h40000
  } state_t;

  state_t state;

  logic [NODE_W-1:0] node_count;
  logic [CH_W-1:0]   channel_count;
  logic [31:0]       noise_power;
  logic [31:0]       power_cap;
  logic [NODE_W-1:0] n_eff;
  logic [CH_W-1:0]   c_eff;

  logic signed [31:0] sink_x;
  logic signed [31:0] sink_y;

  logic [79:0]         node_mem [MAX_NODES];
  logic [47:0]         work_mem [MAX_NODES];
  logic [CH_W-1:0]     ch_mem   [MAX_NODES];
  logic [NODE_AW-1:0]  rank_mem [MAX_NODES];
  logic [79:0]         node_rd;
  logic [47:0]         work_rd;
  logic [CH_W-1:0]     ch_rd;
  logic [NODE_AW-1:0]  rank_rd;

  logic [NODE_W-1:0]  i;
  logic [NODE_W-1:0]  r;
  logic [CH_W-1:0]    k;
  logic [NODE_AW-1:0] node;
  logic [1:0]         dstep;
  logic               pend;
  logic               i_last;
  logic               r_last;

  logic [64:0]  sqx;
  logic [64:0]  sqy;
  logic [65:0]  sq_sum;
  logic [63:0]  d2;
  logic [31:0]  d_r;
  logic [15:0]  tgt;
  logic [31:0]  gain_r;
  logic [15:0]  a_r;
  logic [47:0]  x_r;
  logic [16:0]  e_r;

  logic [MAX_NODES-1:0] picked;
  logic                 have;
  logic [31:0]          best_g;
  logic [NODE_AW-1:0]   sel;
  logic                 cand;
  logic [NODE_AW-1:0]   sel_now;

  logic [LOAD_W-1:0]  load [MAX_CHANNELS];
  logic [CH_W-1:0]    ch_eff;
  logic [CH_AW-1:0]   ch_idx;
  logic [LOAD_W-1:0]  s_cur;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] best_t;
  logic [CH_W-1:0]    best_k;
  logic               better;
  logic [CH_W-1:0]    best_k_now;

  logic signed [32:0] diff_x;
  logic signed [32:0] diff_y;
  logic [32:0]        dx;
  logic [32:0]        dy;

  logic               sq_start;
  logic               sq_done;
  logic [ROOT_W-1:0]  sq_root;
  logic               dv_start;
  logic               dv_done;
  logic [DVD_W-1:0]   dv_quot;
  logic [DVD_W-1:0]   dv_dividend;
  logic [DVS_W-1:0]   dv_divisor;
  logic [DVD_W-1:0]   q_plus;
  logic [31:0]        gain_clamp;
  logic [31:0]        p_sat;

  logic               load_acc;
  logic [NODE_AW-1:0] load_addr;

  assign n_eff = (node_count == '0) ? NODE_W'(1) :
                 (node_count > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : node_count;
  assign c_eff = (channel_count == '0) ? CH_W'(1) :
                 (channel_count > CH_W'(MAX_CHANNELS)) ? CH_W'(MAX_CHANNELS) : channel_count;

  assign i_last = (i + NODE_W'(1)) == n_eff;
  assign r_last = (r + NODE_W'(1)) == n_eff;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign load_acc  = in_valid && !in_stall && !kind;
  assign load_addr = NODE_AW'(node_index - NODE_W'(1));

  // distance and gain
  assign diff_x = {node_rd[79], node_rd[79:48]} - {sink_x[31], sink_x};
  assign diff_y = {node_rd[47], node_rd[47:16]} - {sink_y[31], sink_y};
  assign dx     = diff_x[32] ? 33'(-diff_x) : 33'(diff_x);
  assign dy     = diff_y[32] ? 33'(-diff_y) : 33'(diff_y);
  assign sq_sum = {1'b0, sqx} + {1'b0, sqy};
  assign d2     = (|sq_sum[65:64]) ? '1 : sq_sum[63:0];

  assign q_plus     = dv_quot + DVD_W'(1);
  assign gain_clamp = (|q_plus[DVD_W-1:33]) ? SAT32 :
                      (q_plus[32:1] == '0) ? 32'd1 : q_plus[32:1];
  assign p_sat      = (|dv_quot[DVD_W-1:32]) ? SAT32 : dv_quot[31:0];

  // ranking
  assign cand    = !picked[i[NODE_AW-1:0]] && (!have || (work_rd[47:16] < best_g));
  assign sel_now = cand ? i[NODE_AW-1:0] : sel;

  // trials
  assign ch_eff     = (i[NODE_AW-1:0] == node) ? k : ch_rd;
  assign ch_idx     = CH_AW'(ch_eff - CH_W'(1));
  assign s_cur      = load[ch_idx];
  assign better     = (k == CH_W'(1)) || (total < best_t);
  assign best_k_now = better ? k : best_k;

  assign sq_start = (state == ST_G_SQ) && !pend;
  assign dv_start = ((state == ST_G_DIV) || (state == ST_P_DIV)) && !pend;

  always_comb begin
    dv_dividend = '0;
    dv_divisor  = '0;
    if (state == ST_G_DIV) begin
      unique case (dstep)
        2'd0:    dv_dividend = DVD_W'(GAIN_K2);
        2'd1,
        2'd2:    dv_dividend = dv_quot;
        default: dv_dividend = DVD_W'({tgt, 16'h0000});
      endcase
      dv_divisor = (dstep == 2'd3) ? DVS_W'({1'b1, tgt}) : d_r;
    end else begin
      dv_dividend = (dstep == 2'd0) ? DVD_W'(x_r) : DVD_W'({dv_quot[49:0], 16'h0000});
      dv_divisor  = (dstep == 2'd0) ? gain_r : DVS_W'(e_r);
    end
  end

  gcpa_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (d2),
    .done     (sq_done),
    .root     (sq_root)
  );

  gcpa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_dividend),
    .divisor  (dv_divisor),
    .done     (dv_done),
    .quot     (dv_quot)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count    <= NODE_W'(20);
      channel_count <= CH_W'(4);
      noise_power   <= 32'd65536;
      power_cap     <= 32'd655360000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NODE_COUNT:    node_count    <= cfg_value[NODE_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_value[CH_W-1:0];
        REG_NOISE_POWER:   noise_power   <= cfg_value;
        REG_POWER_CAP:     power_cap     <= cfg_value;
        default: ;
      endcase
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (load_acc && node_index == '0) begin
      sink_x <= pos_x;
      sink_y <= pos_y;
    end
    if (load_acc && node_index != '0 && node_index <= NODE_W'(MAX_NODES)) begin
      node_mem[load_addr] <= {pos_x, pos_y, target_ratio};
    end
    if (state == ST_G_RD) begin
      node_rd <= node_mem[i[NODE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_G_WR) begin
      work_mem[i[NODE_AW-1:0]] <= {gain_r, a_r};
    end
    if (state == ST_R_RD || state == ST_L_RD || state == ST_P_RD) begin
      work_rd <= work_mem[i[NODE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_G_WR) begin
      ch_mem[i[NODE_AW-1:0]] <= CH_W'(1);
    end else if (state == ST_A_CMP && k == c_eff) begin
      ch_mem[node] <= best_k_now;
    end
    if (state == ST_L_RD || state == ST_P_RD || state == ST_O_RD) begin
      ch_rd <= ch_mem[i[NODE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_R_CMP && i_last) begin
      rank_mem[r[NODE_AW-1:0]] <= sel_now;
    end
    if (state == ST_A_RD) begin
      rank_rd <= rank_mem[r[NODE_AW-1:0]];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
      i     <= '0;
      r     <= '0;
      k     <= '0;
      dstep <= '0;
      have  <= 1'b0;
    end else begin
      if (sq_start || dv_start) begin
        pend <= 1'b1;
      end else if (sq_done || dv_done) begin
        pend <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid && kind) begin
            i     <= '0;
            state <= ST_G_RD;
          end
        end
        ST_G_RD: state <= ST_G_MUL;
        ST_G_MUL: begin
          sqx   <= 65'(dx * dx);
          sqy   <= 65'(dy * dy);
          tgt   <= node_rd[15:0];
          state <= ST_G_SQ;
        end
        ST_G_SQ: begin
          if (sq_done) begin
            d_r <= sq_root;
            if (sq_root == '0) begin
              gain_r <= SAT32;
              dstep  <= 2'd3;
            end else begin
              dstep <= 2'd0;
            end
            state <= ST_G_DIV;
          end
        end
        ST_G_DIV: begin
          if (dv_done) begin
            if (dstep == 2'd2) begin
              gain_r <= gain_clamp;
            end
            if (dstep == 2'd3) begin
              a_r   <= dv_quot[15:0];
              state <= ST_G_WR;
            end else begin
              dstep <= dstep + 2'd1;
            end
          end
        end
        ST_G_WR: begin
          if (i_last) begin
            i      <= '0;
            r      <= '0;
            picked <= '0;
            have   <= 1'b0;
            state  <= ST_R_RD;
          end else begin
            i     <= i + NODE_W'(1);
            state <= ST_G_RD;
          end
        end
        ST_R_RD: state <= ST_R_CMP;
        ST_R_CMP: begin
          if (cand) begin
            best_g <= work_rd[47:16];
            sel    <= i[NODE_AW-1:0];
          end
          if (i_last) begin
            picked[sel_now] <= 1'b1;
            have            <= 1'b0;
            i               <= '0;
            if (r_last) begin
              r     <= '0;
              state <= ST_A_RD;
            end else begin
              r     <= r + NODE_W'(1);
              state <= ST_R_RD;
            end
          end else begin
            have  <= have || cand;
            i     <= i + NODE_W'(1);
            state <= ST_R_RD;
          end
        end
        ST_A_RD: state <= ST_A_NODE;
        ST_A_NODE: begin
          node  <= rank_rd;
          k     <= CH_W'(1);
          state <= ST_L_CLR;
        end
        ST_L_CLR: begin
          for (int j = 0; j < MAX_CHANNELS; j++) begin
            load[j] <= '0;
          end
          i     <= '0;
          state <= ST_L_RD;
        end
        ST_L_RD: state <= ST_L_ADD;
        ST_L_ADD: begin
          load[ch_idx] <= load[ch_idx] + LOAD_W'(work_rd[15:0]);
          if (i_last) begin
            i     <= '0;
            total <= '0;
            state <= ST_P_RD;
          end else begin
            i     <= i + NODE_W'(1);
            state <= ST_L_RD;
          end
        end
        ST_P_RD: state <= ST_P_CALC;
        ST_P_CALC: begin
          if (|s_cur[LOAD_W-1:16]) begin
            total <= total + TOTAL_W'(power_cap);
            if (i_last) begin
              state <= ST_A_CMP;
            end else begin
              i     <= i + NODE_W'(1);
              state <= ST_P_RD;
            end
          end else begin
            x_r    <= 48'(work_rd[15:0] * noise_power);
            e_r    <= Q16_ONE - 17'(s_cur);
            gain_r <= work_rd[47:16];
            dstep  <= 2'd0;
            state  <= ST_P_DIV;
          end
        end
        ST_P_DIV: begin
          if (dv_done) begin
            if (dstep == 2'd0) begin
              dstep <= 2'd1;
            end else begin
              total <= total + TOTAL_W'(p_sat);
              if (i_last) begin
                state <= ST_A_CMP;
              end else begin
                i     <= i + NODE_W'(1);
                state <= ST_P_RD;
              end
            end
          end
        end
        ST_A_CMP: begin
          best_t <= better ? total : best_t;
          best_k <= best_k_now;
          if (k == c_eff) begin
            if (r_last) begin
              i     <= '0;
              state <= ST_O_RD;
            end else begin
              r     <= r + NODE_W'(1);
              state <= ST_A_RD;
            end
          end else begin
            k     <= k + CH_W'(1);
            state <= ST_L_CLR;
          end
        end
        ST_O_RD: state <= ST_O_SHOW;
        ST_O_SHOW: begin
          if (!out_stall) begin
            if (i_last) begin
              state <= ST_IDLE;
            end else begin
              i     <= i + NODE_W'(1);
              state <= ST_O_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = (state == ST_O_SHOW);
  assign node_number      = i + NODE_W'(1);
  assign assigned_channel = ch_rd;
  assign is_last          = i_last;

endmodule

>>> hdl/gcpa_chk.sv
module gcpa_chk
  import gcpa_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [NODE_W-1:0] node_number,
  input logic [CH_W-1:0]   assigned_channel,
  input logic              is_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(node_number)
      && $stable(assigned_channel) && $stable(is_last))
    else $error("stalled result changed");

  // no transaction taken while results are pending
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken during result delivery");

  // channel and node numbers start at one
  a_chan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> assigned_channel != '0 && node_number != '0)
    else $error("channel or node zero reported");

  // results come one per node in order
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !is_last |=> ##1 out_valid
      && node_number == $past(node_number, 2) + NODE_W'(1))
    else $error("result order broken");

endmodule

bind greedy_channel_power_assignment gcpa_chk u_gcpa_chk (.*);
